// ----- hw/rtl/gsel_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsel_pkg
// Shared types, register indexes and the exponential table.
// ----------------------------------------------------------------------------
package gsel_pkg;

  localparam int unsigned RegAmplitude  = 0;
  localparam int unsigned RegCenter     = 1;
  localparam int unsigned RegWidth      = 2;
  localparam int unsigned RegRangeLow   = 3;
  localparam int unsigned RegRangeHigh  = 4;
  localparam int unsigned RegSampleCnt  = 5;

  localparam logic [62:0] SumMax = {63{1'b1}};
  localparam logic [18:0] RLimit = 19'd262144;

  typedef struct packed {
    logic start;
  } gsel_cmd_t;

  typedef struct packed {
    logic done;
  } gsel_sts_t;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StBusy = 3'b010,
    StOut  = 3'b100
  } gsel_state_e;

  function automatic logic [16:0] exp_tab(input logic [5:0] k);
    logic [16:0] v;
    case (k)
      6'd0:  v = 17'd65536;
      6'd1:  v = 17'd39750;
      6'd2:  v = 17'd24109;
      6'd3:  v = 17'd14623;
      6'd4:  v = 17'd8869;
      6'd5:  v = 17'd5380;
      6'd6:  v = 17'd3263;
      6'd7:  v = 17'd1979;
      6'd8:  v = 17'd1200;
      6'd9:  v = 17'd728;
      6'd10: v = 17'd442;
      6'd11: v = 17'd268;
      6'd12: v = 17'd162;
      6'd13: v = 17'd99;
      6'd14: v = 17'd60;
      6'd15: v = 17'd36;
      6'd16: v = 17'd22;
      6'd17: v = 17'd13;
      6'd18: v = 17'd8;
      6'd19: v = 17'd5;
      6'd20: v = 17'd3;
      6'd21: v = 17'd2;
      6'd22: v = 17'd1;
      6'd23: v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/gsel_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsel_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gsel_div #(
  parameter int unsigned NumW = 64,
  parameter int unsigned DenW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DenW:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DenW-1:0], quo_q[NumW-1]};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- hw/rtl/gsel_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsel_dp
// Datapath: sample position, normalized offset, exponential, squared error
// and the saturating sum, sequenced in steps over a shared divider.
// ----------------------------------------------------------------------------
module gsel_dp
  import gsel_pkg::*;
#(
  parameter int unsigned MaxSamples = 4096,
  parameter int unsigned IdxW = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gsel_cmd_t         cmd_i,
  output gsel_sts_t         sts_o,
  input  logic signed [31:0] target_i,
  input  logic signed [31:0] amplitude_i,
  input  logic signed [31:0] center_i,
  input  logic [30:0]        width_i,
  input  logic signed [31:0] range_low_i,
  input  logic signed [31:0] range_high_i,
  input  logic [12:0]        sample_count_i,
  input  logic              clear_i,
  output logic [62:0]        loss_o,
  output logic               last_o
);

  localparam int unsigned StepW = 4;
  localparam logic [StepW-1:0] SPos = 4'd0, SPosW = 4'd1, SR = 4'd2, SRW = 4'd3,
    SSq = 4'd4, SExp = 4'd5, SAmp = 4'd6, SErr = 4'd7, SSum = 4'd8, SDone = 4'd9,
    SIdle = 4'd10;

  localparam int unsigned CW = $clog2(MaxSamples + 1);

  logic [StepW-1:0]   step_q;
  logic [IdxW-1:0]    idx_q;
  logic [62:0]        sum_q;
  logic               last_q;
  logic signed [31:0] tgt_q;
  logic signed [63:0] x_q;
  logic [18:0]        absr_q;
  logic [37:0]        r2_q;
  logic signed [17:0] e_q;
  logic signed [49:0] ge_q;
  logic [63:0]        sq_q;

  logic [CW-1:0]      n_eff;
  logic [CW-1:0]      nm1;
  logic               div_start, div_done;
  logic [63:0]        div_num, div_quo;
  logic [31:0]        div_den;
  logic               neg_q;

  logic signed [32:0] span;
  logic signed [46:0] prod_pos;
  logic [46:0]        prod_abs;
  logic signed [64:0] diff_r;
  logic [64:0]        num_abs;
  logic [30:0]        w_eff;
  logic [16:0]        ta, tb, dfr;
  logic [32:0]        prod_e;
  logic signed [32:0] g;
  logic signed [33:0] d;
  logic [32:0]        absd;
  logic [63:0]        room;

  always_comb begin
    if (sample_count_i < 13'd2) n_eff = CW'(2);
    else if ({19'd0, sample_count_i} > 32'(MaxSamples)) n_eff = CW'(MaxSamples);
    else n_eff = CW'(sample_count_i);
  end
  assign nm1   = n_eff - 1'b1;
  assign span  = 33'(range_high_i) - 33'(range_low_i);
  assign prod_pos = $signed({1'b0, idx_q}) * span;
  assign prod_abs = prod_pos[46] ? 47'(-prod_pos) : 47'(prod_pos);
  assign diff_r  = 65'(x_q) - 65'(center_i);
  assign num_abs = diff_r[64] ? 65'(-diff_r) : 65'(diff_r);
  assign w_eff   = (width_i == '0) ? 31'd1 : width_i;
  assign ta  = exp_tab({1'b0, r2_q[19:15]});
  assign tb  = exp_tab({1'b0, r2_q[19:15]} + 6'd1);
  assign dfr = ta - tb;
  assign prod_e = dfr * r2_q[14:0];
  assign g   = 33'(ge_q >>> 16);
  assign d   = 34'(g) - 34'(tgt_q);
  assign absd = d[33] ? 33'(-d) : 33'(d);
  assign room = {1'b0, SumMax} - {1'b0, sum_q};

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    if (step_q == SPos) begin
      div_start = 1'b1;
      div_num   = 64'(prod_abs);
      div_den   = 32'(nm1);
    end else if (step_q == SR) begin
      div_start = 1'b1;
      div_num   = 64'(num_abs[47:0]) << 16;
      div_den   = {1'b0, w_eff};
    end
  end

  gsel_div #(.NumW(64), .DenW(32)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= SIdle;
      idx_q  <= '0;
      sum_q  <= '0;
      last_q <= 1'b0;
    end else begin
      case (step_q)
        SIdle: if (cmd_i.start) step_q <= SPos;
        SPos:  step_q <= SPosW;
        SPosW: if (div_done) step_q <= SR;
        SR:    step_q <= SRW;
        SRW:   if (div_done) step_q <= SSq;
        SSq:   step_q <= SExp;
        SExp:  step_q <= SAmp;
        SAmp:  step_q <= SErr;
        SErr:  step_q <= SSum;
        SSum: begin
          if (sq_q > room) sum_q <= SumMax;
          else sum_q <= sum_q + sq_q[62:0];
          last_q <= (CW'(idx_q) >= nm1);
          step_q <= SDone;
        end
        SDone: begin
          step_q <= SIdle;
          if (last_q) idx_q <= '0;
          else idx_q <= idx_q + 1'b1;
        end
        default: step_q <= SIdle;
      endcase
      if (clear_i) sum_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) tgt_q <= target_i;
    if (step_q == SPos) neg_q <= prod_pos[46];
    if (step_q == SPosW && div_done)
      x_q <= 64'(range_low_i) + (neg_q ? -$signed(div_quo) : $signed(div_quo));
    if (step_q == SRW && div_done)
      absr_q <= (div_quo >= 64'(RLimit)) ? RLimit : div_quo[18:0];
    if (step_q == SSq) r2_q <= 38'((absr_q * absr_q) >> 16);
    if (step_q == SExp)
      e_q <= (absr_q >= RLimit) ? 18'sd0 : $signed({1'b0, ta - 17'(prod_e >> 15)});
    if (step_q == SAmp) ge_q <= 50'(amplitude_i) * 50'(e_q);
    if (step_q == SErr) sq_q <= 64'(absd) * 64'(absd);
  end

  assign sts_o.done = (step_q == SDone);
  assign loss_o = sum_q;
  assign last_o = last_q;

endmodule

// ----- hw/rtl/gsel_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsel_ctrl
// Controller: takes a transfer, starts the datapath, holds the result.
// ----------------------------------------------------------------------------
module gsel_ctrl
  import gsel_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output gsel_cmd_t cmd_o,
  input  gsel_sts_t sts_i,
  input  logic      last_i,
  output logic      load_o,
  output logic      clear_o
);

  gsel_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_valid_i) state_d = StBusy;
      StBusy: if (sts_i.done) state_d = StOut;
      StOut:  if (!out_stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign cmd_o.start = (state_q == StIdle) && in_valid_i;
  assign out_valid_o = (state_q == StOut);
  assign load_o      = (state_q == StBusy) && sts_i.done;
  assign clear_o     = load_o && last_i;

endmodule

// ----- hw/rtl/gaussian_squared_error_loss.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_squared_error_loss
// Running squared error of a fixed-point Gaussian against target samples.
// ----------------------------------------------------------------------------
// Input channel: target_value_i with in_valid_i / in_stall_o; one transfer
// per sample. Output channel: loss_total_o and run_done_o with out_valid_o /
// out_stall_i; one result per sample.
// Each sample runs two 64-step divisions on one shared divider (position,
// then normalized offset) plus a few multiply steps, one sample at a time.
// The result is held in an output register; a stalled receiver holds it and
// the next sample is taken once it is transferred.
// Registers must be written via the APB port while idle; the block does
// not enforce it. Reset restores register defaults and clears index and sum.
// ----------------------------------------------------------------------------
module gaussian_squared_error_loss
  import gsel_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic signed [31:0] target_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [62:0] loss_total_o,
  output logic        run_done_o
);

  localparam int unsigned IdxW = $clog2(MAX_SAMPLES);

  logic signed [31:0] amplitude_q, center_q, range_low_q, range_high_q;
  logic [30:0]        width_q;
  logic [12:0]        sample_count_q;
  gsel_cmd_t cmd;
  gsel_sts_t sts;
  logic      load, clear, last;
  logic [62:0] loss;
  logic [62:0] loss_q;
  logic        done_q;
  logic [2:0]  reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amplitude_q    <= 32'sd65536;
      center_q       <= -32'sd32768;
      width_q        <= 31'd32768;
      range_low_q    <= '0;
      range_high_q   <= 32'sd65536;
      sample_count_q <= 13'd64;
    end else if (psel && penable && pwrite) begin
      case (32'(reg_sel))
        RegAmplitude: amplitude_q    <= pwdata;
        RegCenter:    center_q       <= pwdata;
        RegWidth:     width_q        <= pwdata[30:0];
        RegRangeLow:  range_low_q    <= pwdata;
        RegRangeHigh: range_high_q   <= pwdata;
        RegSampleCnt: sample_count_q <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (32'(reg_sel))
      RegAmplitude: prdata = amplitude_q;
      RegCenter:    prdata = center_q;
      RegWidth:     prdata = {1'b0, width_q};
      RegRangeLow:  prdata = range_low_q;
      RegRangeHigh: prdata = range_high_q;
      RegSampleCnt: prdata = {19'd0, sample_count_q};
      default:      prdata = '0;
    endcase
  end

  gsel_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .cmd_o(cmd), .sts_i(sts), .last_i(last), .load_o(load), .clear_o(clear)
  );

  gsel_dp #(.MaxSamples(MAX_SAMPLES), .IdxW(IdxW)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .target_i(target_value_i),
    .amplitude_i(amplitude_q), .center_i(center_q), .width_i(width_q),
    .range_low_i(range_low_q), .range_high_i(range_high_q),
    .sample_count_i(sample_count_q), .clear_i(clear), .loss_o(loss), .last_o(last)
  );

  always_ff @(posedge clk_i) begin
    if (load) begin
      loss_q <= loss;
      done_q <= last;
    end
  end

  assign loss_total_o = loss_q;
  assign run_done_o   = done_q;

endmodule

// ----- hw/rtl/gsel_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsel_checker
// Port-level checks of the loss block.
// ----------------------------------------------------------------------------
module gsel_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [62:0] loss_total_o,
  input logic        run_done_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(loss_total_o))
    else $error("stalled result changed");

  a_no_take_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");

  a_take_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !out_valid_o)
    else $error("transfer did not start work");

  a_run_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("result repeated");

endmodule

bind gaussian_squared_error_loss gsel_checker u_gsel_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .loss_total_o, .run_done_o
);
